// ===== sv/ecc_pkg.sv =====
// Package for the elevator collective controller: opcodes, count limits,
// reset values and the result word layout. No dependencies.
`timescale 1ns / 1ps

package ecc_pkg;

    localparam int FLOORS_DEFAULT = 8;

    localparam int OP_W    = 2;
    localparam int FLOOR_W = 3;
    localparam int CAP_W   = 4;
    localparam int WAIT_W  = 8;
    localparam int TGT_W   = 4;
    localparam int RIDER_W = 4;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
    localparam logic [OP_W-1:0] OP_BOARD  = 2'd2;
    localparam logic [OP_W-1:0] OP_ALIGHT = 2'd3;

    localparam logic [CAP_W-1:0]   CAP_RESET = 4'd5;
    localparam logic [RIDER_W-1:0] RIDER_MAX = 4'd15;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // Result word, car_floor in the lowest bits.
    typedef struct packed {
        logic               idle;
        logic               accepted;
        logic [RIDER_W-1:0] riders;
        logic               door_open;
        logic               going_up;
        logic [FLOOR_W-1:0] car_floor;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ===== sv/elevator_collective_controller_top.sv =====
// Elevator collective (scan) controller, top level.
// Depends on ecc_pkg for opcodes, limits and the result word layout.
`timescale 1ns / 1ps

//  channel   | direction | fields (low bit first)
//  ----------+-----------+-----------------------------------------------------
//  s_ (in)   | slave     | tuser: opcode[1:0]; tdata: floor[2:0], dest[5:3]
//  m_ (out)  | master    | tdata: car_floor[2:0], going_up[3], door_open[4],
//            |           |        riders[8:5], accepted[9], idle[10]
//  cfg       | write     | cfg_wr_data: car_capacity[3:0]
//
//  Each input word updates the car state in the cycle it is accepted and its
//  result word is registered for m_: one word per cycle while m_tready holds.
//  The output register has a one-word skid stage behind it, so an input word is
//  taken while a result waits; s_tready drops only when both are full.
//  aresetn (synchronous, active low) parks the car at the ground floor, going
//  up, door closed, empty, with all per-floor counts cleared and capacity 5.

module elevator_collective_controller_top #(
    parameter int FLOORS = ecc_pkg::FLOORS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // car_capacity[3:0]
    input  logic                          cfg_wr_en,
    input  logic [ecc_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // floor[2:0], dest[5:3], zero pad above
    input  logic [ecc_pkg::IN_DATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [ecc_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // car_floor[2:0], going_up[3], door_open[4], riders[8:5], accepted[9],
    // idle[10], zero pad above
    output logic [ecc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ecc_pkg::*;

    localparam int PosW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    // compare width: holds any floor field, any position and FLOORS itself
    localparam int CmpW = ((PosW > FLOOR_W) ? PosW : FLOOR_W) + 1;

    // ---------------- state ----------------
    logic [CAP_W-1:0]   cap_reg;
    logic [PosW-1:0]    pos_reg,   pos_next;
    logic               up_reg,    up_next;
    logic               door_reg,  door_next;
    logic [RIDER_W-1:0] riders_reg, riders_next;
    logic [WAIT_W-1:0]  wait_cnt_reg [FLOORS];
    logic [WAIT_W-1:0]  wait_cnt_next [FLOORS];
    logic [TGT_W-1:0]   tgt_cnt_reg  [FLOORS];
    logic [TGT_W-1:0]   tgt_cnt_next [FLOORS];

    // ---------------- input decode ----------------
    logic              s_accept;
    logic [OP_W-1:0]   op;
    logic [CmpW-1:0]   fl_ext, ds_ext, pos_ext;
    logic              fl_ok, ds_ok;

    assign s_accept = s_tvalid && s_tready;
    assign op       = s_tuser;
    assign fl_ext   = CmpW'(s_tdata[FLOOR_W-1:0]);
    assign ds_ext   = CmpW'(s_tdata[2*FLOOR_W-1:FLOOR_W]);
    assign pos_ext  = CmpW'(pos_reg);
    assign fl_ok    = fl_ext < CmpW'(FLOORS);
    assign ds_ok    = ds_ext < CmpW'(FLOORS);

    // ---------------- per-floor flags ----------------
    logic [FLOORS-1:0] fl_hit, ds_hit, pos_hit, above_m, below_m;
    logic [FLOORS-1:0] wait_nz, wait_full, tgt_nz, tgt_full, wants;
    logic [FLOORS-1:0] wait_inc, wait_dec, tgt_inc, tgt_dec, wants_next;

    for (genvar f = 0; f < FLOORS; f++) begin : g_floor
        assign fl_hit[f]    = fl_ext == CmpW'(f);
        assign ds_hit[f]    = ds_ext == CmpW'(f);
        assign pos_hit[f]   = pos_ext == CmpW'(f);
        assign above_m[f]   = CmpW'(f) > pos_ext;
        assign below_m[f]   = CmpW'(f) < pos_ext;
        assign wait_nz[f]   = |wait_cnt_reg[f];
        assign wait_full[f] = &wait_cnt_reg[f];
        assign tgt_nz[f]    = |tgt_cnt_reg[f];
        assign tgt_full[f]  = &tgt_cnt_reg[f];
        assign wants[f]     = wait_nz[f] | tgt_nz[f];

        // each floor's counters update themselves; events are one-hot by opcode
        always_comb begin
            wait_cnt_next[f] = wait_cnt_reg[f];
            tgt_cnt_next[f]  = tgt_cnt_reg[f];
            if (wait_inc[f]) begin
                wait_cnt_next[f] = wait_cnt_reg[f] + WAIT_W'(1);
            end else if (wait_dec[f]) begin
                wait_cnt_next[f] = wait_cnt_reg[f] - WAIT_W'(1);
            end
            if (tgt_inc[f]) begin
                tgt_cnt_next[f] = tgt_cnt_reg[f] + TGT_W'(1);
            end else if (tgt_dec[f]) begin
                tgt_cnt_next[f] = tgt_cnt_reg[f] - TGT_W'(1);
            end
        end

        assign wants_next[f] = (|wait_cnt_next[f]) | (|tgt_cnt_next[f]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                wait_cnt_reg[f] <= '0;
                tgt_cnt_reg[f]  <= '0;
            end else begin
                wait_cnt_reg[f] <= wait_cnt_next[f];
                tgt_cnt_reg[f]  <= tgt_cnt_next[f];
            end
        end
    end

    logic any_req, req_above, req_below;
    logic wait_at_pos, tgt_at_pos, wait_room_fl, tgt_room_ds;

    assign any_req      = |wants;
    assign req_above    = |(wants & above_m);
    assign req_below    = |(wants & below_m);
    assign wait_at_pos  = |(wait_nz & pos_hit);
    assign tgt_at_pos   = |(tgt_nz & pos_hit);
    assign wait_room_fl = |(~wait_full & fl_hit);
    assign tgt_room_ds  = |(~tgt_full & ds_hit);

    // ---------------- passenger events ----------------
    logic at_car, arrive_ok, board_ok, alight_ok, is_tick;

    assign is_tick   = s_accept && (op == OP_TICK);
    assign at_car    = fl_ok && (fl_ext == pos_ext) && door_reg;
    assign arrive_ok = s_accept && (op == OP_ARRIVE) && fl_ok && wait_room_fl;
    assign board_ok  = s_accept && (op == OP_BOARD) && ds_ok && at_car && wait_at_pos
                       && (riders_reg < cap_reg) && (riders_reg < RIDER_MAX)
                       && tgt_room_ds;
    assign alight_ok = s_accept && (op == OP_ALIGHT) && at_car && tgt_at_pos
                       && (riders_reg != '0);

    assign wait_inc = arrive_ok ? fl_hit : '0;
    assign wait_dec = board_ok  ? fl_hit : '0;
    assign tgt_inc  = board_ok  ? ds_hit : '0;
    assign tgt_dec  = alight_ok ? fl_hit : '0;

    // ---------------- tick: door, direction, travel ----------------
    logic hold_floor;
    assign hold_floor = tgt_at_pos || (wait_at_pos && (riders_reg < cap_reg));

    always_comb begin
        door_next   = door_reg;
        up_next     = up_reg;
        pos_next    = pos_reg;
        riders_next = riders_reg;
        if (board_ok) begin
            riders_next = riders_reg + RIDER_W'(1);
        end else if (alight_ok) begin
            riders_next = riders_reg - RIDER_W'(1);
        end
        if (is_tick) begin
            if (!door_reg) begin
                door_next = any_req;
            end else if (!hold_floor) begin
                door_next = 1'b0;
                if (any_req) begin
                    // keep direction while requests lie ahead, else turn around if any lie behind
                    if (up_reg && !req_above && req_below) begin
                        up_next = 1'b0;
                    end else if (!up_reg && !req_below && req_above) begin
                        up_next = 1'b1;
                    end
                    if (up_next && req_above) begin
                        pos_next = pos_reg + PosW'(1);
                    end else if (!up_next && req_below) begin
                        pos_next = pos_reg - PosW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            pos_reg    <= '0;
            up_reg     <= 1'b1;
            door_reg   <= 1'b0;
            riders_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            pos_reg    <= pos_next;
            up_reg     <= up_next;
            door_reg   <= door_next;
            riders_reg <= riders_next;
        end
    end

    // ---------------- result word, output register and skid ----------------
    result_t res_new;
    always_comb begin
        res_new.car_floor = FLOOR_W'(pos_next);
        res_new.going_up  = up_next;
        res_new.door_open = door_next;
        res_new.riders    = riders_next;
        res_new.accepted  = arrive_ok || board_ok || alight_ok;
        res_new.idle      = ~|wants_next;
    end

    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            // output stalled: a new word parks in the skid stage
            if (s_accept) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_tready) begin
            if (s_accept) begin
                skid_reg <= res_new;
            end
        end else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (s_accept) begin
            out_reg <= res_new;
        end
    end

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while the output register is empty");

    a_door_opens_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(door_reg) |-> $past(is_tick))
        else $error("door opened without a tick");

    a_move_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(pos_reg) |-> !door_reg && $past(door_reg))
        else $error("car moved without closing its door on that tick");

    a_riders_at_open_door: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(riders_reg) |-> door_reg && $past(door_reg))
        else $error("rider count changed with the door closed");

    a_board_within_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        board_ok |-> riders_reg < cap_reg)
        else $error("boarding accepted at or above capacity");

endmodule
